### design/bfs_pkg.sv
// Shared types and constants for the breadth-first search block.
package bfs_pkg;

  localparam int VERTEX_W   = 5;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDIRECTED   = 2'd1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_EDGE_REV,
    ST_START,
    ST_FETCH,
    ST_ROW,
    ST_SCAN,
    ST_EMIT
  } bfs_state_e;

  typedef struct packed {
    logic capture;
    logic wr_fwd;
    logic wr_rev;
    logic start;
    logic fetch;
    logic row_rd;
    logic enq;
    logic emit;
  } bfs_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic undirected;
    logic src_ok;
    logic cand_any;
    logic queue_empty;
    logic out_free;
  } bfs_status_t;

endpackage

### design/bfs_ctrl.sv
// Sequencer for edge loads and the search loop.
module bfs_ctrl
  import bfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        kind_i,
  input  bfs_status_t status_i,
  output logic        in_ready_o,
  output bfs_cmd_t    cmd_o
);

  bfs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i == KIND_START) ? ST_START : ST_EDGE;
        end
      end
      ST_EDGE: begin
        state_d = (status_i.edge_ok && status_i.undirected) ? ST_EDGE_REV : ST_IDLE;
      end
      ST_EDGE_REV: state_d = ST_IDLE;
      ST_START: begin
        state_d = status_i.src_ok ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: state_d = ST_ROW;
      ST_ROW:   state_d = ST_SCAN;
      ST_SCAN: begin
        if (!status_i.cand_any) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.queue_empty ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EDGE:     cmd_o.wr_fwd = status_i.edge_ok;
      ST_EDGE_REV: cmd_o.wr_rev = 1'b1;
      ST_START:    cmd_o.start  = 1'b1;
      ST_FETCH:    cmd_o.fetch  = 1'b1;
      ST_ROW:      cmd_o.row_rd = 1'b1;
      ST_SCAN:     cmd_o.enq    = status_i.cand_any;
      ST_EMIT:     cmd_o.emit   = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### design/bfs_dp.sv
// Datapath: adjacency memory, vertex queue, visited mask, config and result registers.
module bfs_dp
  import bfs_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfs_cmd_t              cmd_i,
  output bfs_status_t           status_o,
  input  logic [VERTEX_W-1:0]   from_vertex_i,
  input  logic [VERTEX_W-1:0]   to_vertex_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VERTEX_W-1:0]   vertex_o,
  output logic                  last_o
);

  localparam int VN = (MAX_VERTICES > 32) ? 32 : MAX_VERTICES;
  localparam int IW = $clog2(VN);
  localparam int CW = $clog2(VN + 1);

  logic [COUNT_W-1:0]  vc_q;
  logic                und_q;
  logic [COUNT_W-1:0]  n_eff;
  logic [VN-1:0]       act_mask;

  logic [VERTEX_W-1:0] from_q, to_q;
  logic [IW-1:0]       from_idx, to_idx;

  logic [VN-1:0]       adj_mem [VN];
  logic [VN-1:0]       row_vld_q;
  logic [VN-1:0]       row_q;
  logic                adj_we;
  logic [IW-1:0]       wr_addr, wr_bit;

  logic [IW-1:0]       fifo_mem [VN];
  logic [IW-1:0]       cur_q;
  logic [CW-1:0]       head_q, tail_q;
  logic [VN-1:0]       visited_q;
  logic [VN-1:0]       cand;
  logic [IW-1:0]       enq_idx;

  logic                out_vld_q;
  logic [VERTEX_W-1:0] vertex_q;
  logic                last_q;
  logic                out_free;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= VERTEX_COUNT_RST;
      und_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VERTEX_COUNT: vc_q  <= cfg_data_i[COUNT_W-1:0];
        REG_UNDIRECTED:   und_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign n_eff = (vc_q > COUNT_W'(VN)) ? COUNT_W'(VN) : vc_q;

  always_comb begin
    for (int w = 0; w < VN; w++) begin
      act_mask[w] = (COUNT_W'(w) < n_eff);
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      from_q <= from_vertex_i;
      to_q   <= to_vertex_i;
    end
  end

  assign from_idx = IW'(from_q);
  assign to_idx   = IW'(to_q);

  // adjacency memory, one row write per cycle
  assign adj_we  = cmd_i.wr_fwd || cmd_i.wr_rev;
  assign wr_addr = cmd_i.wr_rev ? to_idx : from_idx;
  assign wr_bit  = cmd_i.wr_rev ? from_idx : to_idx;

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      if (row_vld_q[wr_addr]) begin
        adj_mem[wr_addr][wr_bit] <= 1'b1;
      end else begin
        adj_mem[wr_addr] <= {{(VN-1){1'b0}}, 1'b1} << wr_bit;
      end
    end
    if (cmd_i.row_rd) begin
      row_q <= row_vld_q[cur_q] ? adj_mem[cur_q] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (adj_we) begin
      row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // neighbor selection, lowest index first
  assign cand = row_q & ~visited_q & act_mask;

  always_comb begin
    enq_idx = '0;
    for (int w = VN - 1; w >= 0; w--) begin
      if (cand[w]) begin
        enq_idx = IW'(w);
      end
    end
  end

  // vertex queue
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      fifo_mem[0] <= from_idx;
    end else if (cmd_i.enq) begin
      fifo_mem[tail_q[IW-1:0]] <= enq_idx;
    end
    if (cmd_i.fetch) begin
      cur_q <= fifo_mem[head_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      visited_q <= '0;
    end else if (cmd_i.start) begin
      head_q <= '0;
      if (status_o.src_ok) begin
        tail_q    <= CW'(1);
        visited_q <= {{(VN-1){1'b0}}, 1'b1} << from_idx;
      end else begin
        tail_q    <= '0;
        visited_q <= '0;
      end
    end else begin
      if (cmd_i.fetch) begin
        head_q <= head_q + CW'(1);
      end
      if (cmd_i.enq) begin
        tail_q             <= tail_q + CW'(1);
        visited_q[enq_idx] <= 1'b1;
      end
    end
  end

  // result register
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      vertex_q <= VERTEX_W'(cur_q);
      last_q   <= (head_q == tail_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign vertex_o    = vertex_q;
  assign last_o      = last_q;

  assign status_o.edge_ok     = (COUNT_W'(from_q) < n_eff) && (COUNT_W'(to_q) < n_eff);
  assign status_o.undirected  = und_q;
  assign status_o.src_ok      = (COUNT_W'(from_q) < n_eff);
  assign status_o.cand_any    = |cand;
  assign status_o.queue_empty = (head_q == tail_q);
  assign status_o.out_free    = out_free;

  a_visited_matches_tail: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $countones(visited_q) == int'(tail_q)
  ) else $error("visited mask and queue tail disagree");

  a_head_not_past_tail: assert property (
    @(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q
  ) else $error("queue head passed tail");

  a_tail_in_capacity: assert property (
    @(posedge clk_i) disable iff (!rst_ni) int'(tail_q) <= VN
  ) else $error("queue tail beyond capacity");

  a_emit_needs_slot: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_i.emit |=> out_vld_q
  ) else $error("emitted result not held in output register");

endmodule

### design/bfs_adjacency_matrix.sv
// Top level of the breadth-first search over an adjacency bit matrix.
// An edge request writes the forward edge in one state and, when undirected mode is on,
// the reverse edge in a second state, since the adjacency memory takes one row write per
// cycle. A search request first seeds the queue with the source vertex, then for each
// vertex reached does one queue read, one registered adjacency row read, one queue write
// per new neighbor through the single queue write port, and one hand-off of the vertex to
// the output register (which waits while the output is stalled). The matrix is empty after
// reset and needs no clearing pass; configuration writes are taken at any time.
module bfs_adjacency_matrix
  import bfs_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [VERTEX_W-1:0]   from_vertex_i,
  input  logic [VERTEX_W-1:0]   to_vertex_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VERTEX_W-1:0]   vertex_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  bfs_cmd_t    cmd;
  bfs_status_t status;

  assign cfg_ready_o = 1'b1;

  bfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  bfs_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vertex_o      (vertex_o),
    .last_o        (last_o)
  );

endmodule
